// ===== rtl/quadrature_speed_estimator_core_macros.svh =====
// Assertion macros for the quadrature speed estimator core.
// Included by the top-level RTL file, which carries the concurrent checks; no other dependencies.
`ifndef QUADRATURE_SPEED_ESTIMATOR_CORE_MACROS_SVH
`define QUADRATURE_SPEED_ESTIMATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define QSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qse: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qse: next-cycle check failed");

`else

`define QSE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QSE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/qse_pkg.sv =====
// Shared types and constants for the quadrature speed estimator core.
// No dependencies; imported by qse_muldiv and the top level.
`timescale 1ns / 1ps

package qse_pkg;

    // Width of the encoder counter actually used from counter_value.
    localparam int COUNT_WIDTH = 16;
    localparam logic [15:0] CNT_MASK = 16'((33'(1) << COUNT_WIDTH) - 33'(1));

    // Shared unit datapath width and top divider step index.
    localparam int UNIT_W = 64;
    localparam logic [3:0] DIV_TOP = 4'd15;

    // Percent scale factor.
    localparam logic [31:0] PCT_FACTOR = 32'd100;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COUNTS_PER_REV = 2'd0;
    localparam logic [1:0] CFG_RPM_SCALE      = 2'd1;
    localparam logic [1:0] CFG_MAX_SPEED      = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] RST_COUNTS_PER_REV = 16'd1440;
    localparam logic [31:0] RST_RPM_SCALE      = 32'd273067;
    localparam logic [15:0] RST_MAX_SPEED      = 16'd3000;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_unit_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP_GO,
        S_WRAP_WAIT,
        S_RPM_GO,
        S_RPM_WAIT,
        S_PCT_GO,
        S_PCT_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

endpackage

// ===== rtl/qse_muldiv.sv =====
// Iterative shift-add multiplier and restoring divider sharing one 64-bit adder.
// Depends on qse_pkg for the request and response types.
`timescale 1ns / 1ps

module qse_muldiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qse_pkg::t_unit_req   i_req,
    input  logic [63:0]          i_a,      // multiplicand or dividend
    input  logic [31:0]          i_b,      // multiplier, or divisor in the low 16 bits
    output qse_pkg::t_unit_rsp   o_rsp,
    output logic [63:0]          o_result
);
    import qse_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_sat;
    t_op               r_op;
    logic [UNIT_W-1:0] r_x;     // accumulator or partial remainder
    logic [UNIT_W-1:0] r_y;     // shifted multiplicand or shifted divisor
    logic [31:0]       r_z;     // remaining multiplier bits or quotient
    logic [3:0]        r_step;

    logic              w_sub;
    logic [UNIT_W:0]   w_sum;
    logic              w_carry;
    logic              w_mul_end;
    logic              w_div_end;

    // The one shared adder: add for multiply, subtract-and-compare for divide.
    assign w_sub   = (r_op == OP_DIV);
    assign w_sum   = {1'b0, r_x} + {1'b0, (w_sub ? ~r_y : r_y)} + (UNIT_W + 1)'(w_sub);
    assign w_carry = w_sum[UNIT_W];

    // Multiply ends once no multiplier bits remain; divide after the last
    // quotient bit, or early when the top step shows the quotient overflows.
    assign w_mul_end = (r_z == 32'd0);
    assign w_div_end = (r_step == 4'd0) || ((r_step == DIV_TOP) && w_carry);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if ((r_op == OP_MUL) ? w_mul_end : w_div_end) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_sat  <= 1'b0;
            r_step <= DIV_TOP;
            if (i_req.op == OP_MUL) begin
                r_x <= '0;
                r_y <= i_a;
                r_z <= i_b;
            end else begin
                r_x <= i_a;
                r_y <= UNIT_W'(i_b[15:0]) << DIV_TOP;
                r_z <= 32'd0;
            end
        end else if (r_busy) begin
            unique case (r_op)
                OP_MUL: begin
                    if (!w_mul_end) begin
                        if (r_z[0]) begin
                            r_x <= w_sum[UNIT_W-1:0];
                        end
                        r_y <= r_y << 1;
                        r_z <= r_z >> 1;
                    end
                end
                OP_DIV: begin
                    if (w_carry) begin
                        r_x <= w_sum[UNIT_W-1:0];
                    end
                    r_z <= {r_z[30:0], w_carry};
                    r_y <= r_y >> 1;
                    if ((r_step == DIV_TOP) && w_carry) begin
                        r_sat <= 1'b1;
                    end
                    if (r_step != 4'd0) begin
                        r_step <= r_step - 4'd1;
                    end
                end
                default: begin
                    r_z <= r_z;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_result   = (r_op == OP_MUL) ? r_x : UNIT_W'(r_z[15:0]);

endmodule

// ===== rtl/quadrature_speed_estimator_core.sv =====
// Quadrature encoder speed estimator (M method): count delta to rpm and percent.
// A priming request skips the arithmetic and goes straight to the output state.
// Requests are taken one at a time, only in the idle state; the shared multiply/divide
// unit runs four bit-serial passes (wrap product, rpm scaling, times 100, 16-step division).
// A finished result may wait in the output register while the next request is taken.
// Reset (synchronous, active low) restores default registers, clears the count and primed flag.
`timescale 1ns / 1ps

`include "quadrature_speed_estimator_core_macros.svh"

module quadrature_speed_estimator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input request channel.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] counter_value, [16] count_down,
                                     // [24:17] wrap_count, [31:25] zero
    // Result channel.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [31:0] speed_rpm_q8, [47:32] speed_percent_q8
    output logic [0:0]  o_m_tuser,   // [0] first_sample
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import qse_pkg::*;

    t_state      r_state;
    t_state      n_state;

    // Configuration and persistent state.
    logic [15:0] r_cpr;
    logic [31:0] r_scale;
    logic [15:0] r_max;
    logic [15:0] r_prev;
    logic        r_primed;

    // Per-request working registers.
    logic [15:0] r_cur;
    logic [15:0] r_prev_old;
    logic        r_down;
    logic [7:0]  r_wraps;
    logic        r_first;
    logic        r_neg;
    logic [24:0] r_mag;
    logic [30:0] r_rpm;
    logic [38:0] r_dividend;
    logic [14:0] r_pct;

    // Output register.
    logic        r_m_valid;
    logic [47:0] r_m_data;
    logic        r_m_first;

    // Shared unit interface.
    t_unit_req   w_req;
    t_unit_rsp   w_rsp;
    logic [63:0] w_ua;
    logic [31:0] w_ub;
    logic [63:0] w_ures;

    logic        w_in_acc;
    logic        w_out_free;
    logic        w_unit_wait;
    logic [15:0] w_cnt;
    logic [25:0] w_prod_wrap;
    logic [25:0] w_delta;
    logic [25:0] w_abs;
    logic [57:0] w_rnd;
    logic [49:0] w_rpm_full;
    logic [30:0] w_rpm_next;
    logic [38:0] w_div_next;
    logic [14:0] w_pct_next;
    logic [31:0] w_rpm_ext;
    logic [31:0] w_rpm_bits;
    logic [15:0] w_pct_ext;
    logic [15:0] w_pct_bits;

    qse_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_a      (w_ua),
        .i_b      (w_ub),
        .o_rsp    (w_rsp),
        .o_result (w_ures)
    );

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_cnt      = i_s_tdata[15:0] & CNT_MASK;

    // The sequencer is waiting on a pass of the shared unit.
    assign w_unit_wait = (r_state == S_WRAP_WAIT) || (r_state == S_RPM_WAIT) ||
                         (r_state == S_PCT_WAIT) || (r_state == S_DIV_WAIT);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_primed ? S_WRAP_GO : S_OUT;
                end
            end
            S_WRAP_GO:   n_state = S_WRAP_WAIT;
            S_WRAP_WAIT: n_state = w_rsp.done ? S_RPM_GO : S_WRAP_WAIT;
            S_RPM_GO:    n_state = S_RPM_WAIT;
            S_RPM_WAIT:  n_state = w_rsp.done ? S_PCT_GO : S_RPM_WAIT;
            S_PCT_GO:    n_state = S_PCT_WAIT;
            S_PCT_WAIT:  n_state = w_rsp.done ? S_DIV_GO : S_PCT_WAIT;
            S_DIV_GO:    n_state = S_DIV_WAIT;
            S_DIV_WAIT:  n_state = w_rsp.done ? S_OUT : S_DIV_WAIT;
            S_OUT:       n_state = w_out_free ? S_IDLE : S_OUT;
            default:     n_state = S_IDLE;
        endcase
    end

    // State outputs: input ready and shared unit requests.
    always_comb begin
        o_s_tready = 1'b0;
        w_req.start = 1'b0;
        w_req.op    = OP_MUL;
        w_ua        = '0;
        w_ub        = '0;
        unique case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_WRAP_GO: begin
                w_req.start = 1'b1;
                w_ua        = 64'(r_cpr);
                w_ub        = 32'(r_wraps);
            end
            S_RPM_GO: begin
                w_req.start = 1'b1;
                w_ua        = 64'(r_scale);
                w_ub        = 32'(r_mag);
            end
            S_PCT_GO: begin
                w_req.start = 1'b1;
                w_ua        = 64'(r_rpm);
                w_ub        = PCT_FACTOR;
            end
            S_DIV_GO: begin
                w_req.start = 1'b1;
                w_req.op    = OP_DIV;
                w_ua        = 64'(r_dividend);
                w_ub        = 32'(r_max);
            end
            default: o_s_tready = 1'b0;
        endcase
    end

    // Signed delta: plain difference plus or minus whole revolutions.
    assign w_prod_wrap = 26'(w_ures[23:0]);
    assign w_delta = 26'(r_cur) - 26'(r_prev_old)
                   + (r_down ? (26'd0 - w_prod_wrap) : w_prod_wrap);
    assign w_abs   = w_delta[25] ? (26'd0 - w_delta) : w_delta;

    // Rpm magnitude rounded to nearest, saturated to 31 bits.
    assign w_rnd      = {1'b0, w_ures[56:0]} + 58'd128;
    assign w_rpm_full = w_rnd[57:8];
    assign w_rpm_next = (|w_rpm_full[49:31]) ? {31{1'b1}} : w_rpm_full[30:0];

    // Dividend for the percent, with half the divisor added for rounding.
    assign w_div_next = {1'b0, w_ures[37:0]} + 39'(r_max[15:1]);

    // Percent magnitude; zero speed stays zero even with a zero maximum.
    assign w_pct_next = (r_rpm == 31'd0) ? 15'd0 :
                        (w_rsp.sat ? {15{1'b1}} : w_ures[14:0]);

    // Apply the sign of the delta to both results.
    assign w_rpm_ext  = {1'b0, r_rpm};
    assign w_rpm_bits = r_neg ? (32'd0 - w_rpm_ext) : w_rpm_ext;
    assign w_pct_ext  = {1'b0, r_pct};
    assign w_pct_bits = r_neg ? (16'd0 - w_pct_ext) : w_pct_ext;

    // Control state, configuration, persistent count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cpr     <= RST_COUNTS_PER_REV;
            r_scale   <= RST_RPM_SCALE;
            r_max     <= RST_MAX_SPEED;
            r_prev    <= 16'd0;
            r_primed  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_COUNTS_PER_REV: r_cpr   <= i_cfg_data[15:0];
                    CFG_RPM_SCALE:      r_scale <= i_cfg_data;
                    CFG_MAX_SPEED:      r_max   <= i_cfg_data[15:0];
                    default:            r_cpr   <= r_cpr;
                endcase
            end
            if (w_in_acc) begin
                r_prev   <= w_cnt;
                r_primed <= 1'b1;
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Working registers, loaded on acceptance, after each shared unit pass and at output.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cur      <= w_cnt;
            r_prev_old <= r_prev;
            r_down     <= i_s_tdata[16];
            r_wraps    <= i_s_tdata[24:17];
            r_first    <= !r_primed;
        end
        if ((r_state == S_WRAP_WAIT) && w_rsp.done) begin
            r_neg <= w_delta[25];
            r_mag <= w_abs[24:0];
        end
        if ((r_state == S_RPM_WAIT) && w_rsp.done) begin
            r_rpm <= w_rpm_next;
        end
        if ((r_state == S_PCT_WAIT) && w_rsp.done) begin
            r_dividend <= w_div_next;
        end
        if ((r_state == S_DIV_WAIT) && w_rsp.done) begin
            r_pct <= w_pct_next;
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_m_data  <= r_first ? 48'd0 : {w_pct_bits, w_rpm_bits};
            r_m_first <= r_first;
        end
    end

    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_m_tuser   = r_m_first;
    assign o_cfg_ready = 1'b1;

    // A priming request skips all arithmetic passes.
    `QSE_ASSERT_NXT(a_prime_skips, i_clk, i_rst_n, w_in_acc && !r_primed, r_state == S_OUT)

    // The shared unit only reports completion while the sequencer waits on it.
    `QSE_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, w_rsp.done, w_unit_wait)

    // A priming result carries zero speed.
    `QSE_ASSERT_IMP(a_first_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata == 48'd0)

    // Leaving the output state always presents a result.
    `QSE_ASSERT_NXT(a_out_loads, i_clk, i_rst_n, (r_state == S_OUT) && w_out_free, o_m_tvalid)

endmodule
